// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the patch extractor RTL.
// No dependencies; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define IPE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define IPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`IPE_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ----- rtl/ipe_pkg.sv -----
// Package of the image patch extractor: field widths, register indexes,
// reset values and the job descriptor passed from front to back. No dependencies.
`timescale 1ns / 1ps

package ipe_pkg;

	localparam int BYTE_W     = 8;
	localparam int VAL_W      = 16;
	localparam int IDX_W      = 20;
	localparam int ELEM_W     = 6;
	localparam int IMG_CFG_W  = 11;
	localparam int SIDE_CFG_W = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	// offsets inside a patch and patch counts minus one, sized for sides up to 8
	localparam int OFS_W      = 3;

	localparam int MAX_PATCH_SIDE_DEF = 8;
	localparam int MAX_IMAGE_SIDE_DEF = 1024;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATCH_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATCH_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 3'd6;

	localparam logic [IMG_CFG_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [IMG_CFG_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [SIDE_CFG_W-1:0] RST_PATCH_WIDTH  = 4'd8;
	localparam logic [SIDE_CFG_W-1:0] RST_PATCH_HEIGHT = 4'd8;
	localparam logic [SIDE_CFG_W-1:0] RST_STEP_X       = 4'd4;
	localparam logic [SIDE_CFG_W-1:0] RST_STEP_Y       = 4'd4;

	// width of a clamped image side or a patch count
	function automatic int size_width(input int max_side);
		return ($clog2(max_side + 1) > IMG_CFG_W) ? $clog2(max_side + 1) : IMG_CFG_W;
	endfunction

	typedef struct packed {
		logic [SIDE_CFG_W-1:0] step_x;
		logic [SIDE_CFG_W-1:0] step_y;
		logic [SIDE_CFG_W-1:0] patch_w;
	} geom_t;

	// one covered pixel: the patch block it touches and its plane values
	typedef struct packed {
		logic [IDX_W-1:0] base_idx;
		logic [OFS_W-1:0] cnt_x_m1;
		logic [OFS_W-1:0] cnt_y_m1;
		logic [OFS_W-1:0] offx_lo;
		logic [OFS_W-1:0] offy_lo;
		logic [VAL_W-1:0] plane0;
		logic [VAL_W-1:0] plane1;
		logic [VAL_W-1:0] plane2;
		logic             unit;
	} patch_job_t;

endpackage

// ----- rtl/ipe_stream_ifs.sv -----
// Valid/ready stream interfaces: pixel input and patch result output.
// Depends on ipe_pkg for field widths.
`timescale 1ns / 1ps

interface ipe_pixel_if import ipe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] blue_byte;
	logic [BYTE_W-1:0] green_byte;
	logic [BYTE_W-1:0] red_byte;
	logic [VAL_W-1:0]  depth_sample;

	modport source (output valid, blue_byte, green_byte, red_byte, depth_sample,
		input ready);
	modport sink (input valid, blue_byte, green_byte, red_byte, depth_sample,
		output ready);
endinterface

interface ipe_patch_if import ipe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  patch_index;
	logic [ELEM_W-1:0] element_offset;
	logic [VAL_W-1:0]  plane0_value;
	logic [VAL_W-1:0]  plane1_value;
	logic [VAL_W-1:0]  plane2_value;
	logic              unit_value;
	logic              last_for_pixel;

	modport source (output valid, patch_index, element_offset, plane0_value,
		plane1_value, plane2_value, unit_value, last_for_pixel, input ready);
	modport sink (input valid, patch_index, element_offset, plane0_value,
		plane1_value, plane2_value, unit_value, last_for_pixel, output ready);
endinterface

// ----- rtl/ipe_front.sv -----
// Front end: configuration registers, raster position, patch coverage of each pixel.
// Depends on ipe_pkg, ipe_pixel_if and assert_macros.svh; feeds ipe_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipe_front import ipe_pkg::*; #(
	parameter int MAX_PATCH_SIDE = MAX_PATCH_SIDE_DEF,
	parameter int MAX_IMAGE_SIDE = MAX_IMAGE_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	ipe_pixel_if.sink                     pixel_in,
	output patch_job_t                    job,
	output logic                          job_valid,
	input  logic                          job_ready,
	output geom_t                         geom,
	output logic [size_width(MAX_IMAGE_SIDE)-1:0] nx
);

	localparam int PW  = $clog2(MAX_IMAGE_SIDE);
	localparam int SZW = size_width(MAX_IMAGE_SIDE);
	localparam int DW  = SZW + 1;
	localparam int RS  = DW + 3;
	localparam int RW  = RS + 1;
	localparam int PRW = DW + RW;
	localparam int KW  = SZW + SIDE_CFG_W;
	localparam int BW  = 2 * SZW + 1;

	typedef enum logic [1:0] {F_IDLE, F_HI, F_LO, F_PUSH} fstate_t;

	// ceil(2^RS / d): floor(n * recip(d) >> RS) is exact for n < 2^DW, d <= 8
	function automatic logic [RW-1:0] recip(input logic [SIDE_CFG_W-1:0] d);
		logic [RW-1:0] r;
		case (d)
			'd2:     r = RW'((2**RS + 1) / 2);
			'd3:     r = RW'((2**RS + 2) / 3);
			'd4:     r = RW'((2**RS + 3) / 4);
			'd5:     r = RW'((2**RS + 4) / 5);
			'd6:     r = RW'((2**RS + 5) / 6);
			'd7:     r = RW'((2**RS + 6) / 7);
			'd8:     r = RW'((2**RS + 7) / 8);
			default: r = RW'(2**RS);
		endcase
		return r;
	endfunction

	function automatic logic [SZW-1:0] clamp_size(input logic [IMG_CFG_W-1:0] v);
		logic [SZW-1:0] r;
		if (v == '0)
			r = SZW'(1);
		else if (SZW'(v) > SZW'(MAX_IMAGE_SIDE))
			r = SZW'(MAX_IMAGE_SIDE);
		else
			r = SZW'(v);
		return r;
	endfunction

	function automatic logic [SIDE_CFG_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v);
		logic [SIDE_CFG_W-1:0] r;
		if (v == '0)
			r = SIDE_CFG_W'(1);
		else if (v > SIDE_CFG_W'(MAX_PATCH_SIDE))
			r = SIDE_CFG_W'(MAX_PATCH_SIDE);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [SZW-1:0] patch_count(input logic [SZW-1:0] size,
			input logic [SIDE_CFG_W-1:0] side, input logic [SIDE_CFG_W-1:0] step);
		logic [DW-1:0]  num;
		logic [PRW-1:0] prod;
		num  = (size > SZW'(side)) ? DW'(size) - DW'(side) + DW'(step) - DW'(1) : '0;
		prod = PRW'(num) * PRW'(recip(step));
		return SZW'(prod >> RS);
	endfunction

	// last covering patch counted back from the highest: t steps while still inside
	function automatic logic [OFS_W-1:0] span_m1(input logic [OFS_W-1:0] offh,
			input logic [SZW-1:0] khi, input logic [SIDE_CFG_W-1:0] step,
			input logic [SIDE_CFG_W-1:0] side);
		logic [OFS_W-1:0] tm;
		logic [7:0]       sum;
		tm = '0;
		for (int t = 0; t < MAX_PATCH_SIDE; t++) begin
			sum = 8'(offh) + 8'(t) * 8'(step);
			if (sum < 8'(side) && SZW'(t) <= khi)
				tm = OFS_W'(t);
		end
		return tm;
	endfunction

	// configuration
	logic [IMG_CFG_W-1:0]  img_w_q, img_h_q;
	logic [SIDE_CFG_W-1:0] patch_w_q, patch_h_q, step_x_q, step_y_q;
	logic                  depth_q;
	logic                  settle_q;
	logic [SZW-1:0]        nx_q, ny_q;
	geom_t                 geom_q;

	logic [SZW-1:0]        w_c, h_c;
	logic [SIDE_CFG_W-1:0] pw_c, ph_c, sx_c, sy_c;

	// control
	fstate_t               state_q;
	logic [PW-1:0]         col_q, row_q;
	logic                  accept;
	logic [SZW:0]          col_inc, row_inc;

	// per-item work registers
	logic [VAL_W-1:0]      p0_q, p1_q, p2_q;
	logic                  unit_q;
	logic [PW-1:0]         col_at_q, row_at_q;
	logic                  inside_q;
	logic [SZW-1:0]        bx_q, by_q;
	logic [SZW-1:0]        khx_q, khy_q;
	logic [OFS_W-1:0]      offhx_q, offhy_q;
	logic                  covx_q, covy_q;
	logic [OFS_W-1:0]      tmx_q, tmy_q;
	logic [SZW-1:0]        ilo_q, jlo_q;
	logic [OFS_W-1:0]      offlx_q, offly_q;

	logic [PRW-1:0]        bx_prod, by_prod;
	logic [SZW-1:0]        nxm1, nym1, khx_d, khy_d;
	logic [KW-1:0]         diffx, diffy;
	logic [OFS_W-1:0]      tmx_d, tmy_d;
	logic [BW-1:0]         base_full;

	assign w_c  = clamp_size(img_w_q);
	assign h_c  = clamp_size(img_h_q);
	assign pw_c = clamp_side(patch_w_q);
	assign ph_c = clamp_side(patch_h_q);
	assign sx_c = clamp_side(step_x_q);
	assign sy_c = clamp_side(step_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q   <= RST_IMAGE_WIDTH;
			img_h_q   <= RST_IMAGE_HEIGHT;
			patch_w_q <= RST_PATCH_WIDTH;
			patch_h_q <= RST_PATCH_HEIGHT;
			step_x_q  <= RST_STEP_X;
			step_y_q  <= RST_STEP_Y;
			depth_q   <= 1'b0;
			settle_q  <= 1'b1;
		end else begin
			settle_q <= cfg_write;
			if (cfg_write) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  img_w_q   <= cfg_data[IMG_CFG_W-1:0];
					REG_IMAGE_HEIGHT: img_h_q   <= cfg_data[IMG_CFG_W-1:0];
					REG_PATCH_WIDTH:  patch_w_q <= cfg_data[SIDE_CFG_W-1:0];
					REG_PATCH_HEIGHT: patch_h_q <= cfg_data[SIDE_CFG_W-1:0];
					REG_STEP_X:       step_x_q  <= cfg_data[SIDE_CFG_W-1:0];
					REG_STEP_Y:       step_y_q  <= cfg_data[SIDE_CFG_W-1:0];
					REG_DEPTH_MODE:   depth_q   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// derived geometry, registered from the configuration registers (settle_q covers the update after a write)
	always_ff @(posedge clk) begin
		nx_q           <= patch_count(w_c, pw_c, sx_c);
		ny_q           <= patch_count(h_c, ph_c, sy_c);
		geom_q.step_x  <= sx_c;
		geom_q.step_y  <= sy_c;
		geom_q.patch_w <= pw_c;
	end

	assign pixel_in.ready = (state_q == F_IDLE) && !settle_q;
	assign accept         = pixel_in.valid && pixel_in.ready;

	assign col_inc = (SZW+1)'(col_q) + (SZW+1)'(1);
	assign row_inc = (SZW+1)'(row_q) + (SZW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_HI;
						if (col_inc >= (SZW+1)'(w_c)) begin
							col_q <= '0;
							if (row_inc >= (SZW+1)'(h_c))
								row_q <= '0;
							else
								row_q <= PW'(row_inc);
						end else begin
							col_q <= PW'(col_inc);
						end
					end
				end
				F_HI: state_q <= F_LO;
				F_LO: state_q <= (inside_q && covx_q && covy_q) ? F_PUSH : F_IDLE;
				F_PUSH: begin
					if (job_ready)
						state_q <= F_IDLE;
				end
			endcase
		end
	end

	// highest patch index not past the pixel, per axis
	assign bx_prod = PRW'(col_q) * PRW'(recip(sx_c));
	assign by_prod = PRW'(row_q) * PRW'(recip(sy_c));

	assign nxm1  = nx_q - SZW'(1);
	assign nym1  = ny_q - SZW'(1);
	assign khx_d = (bx_q > nxm1) ? nxm1 : bx_q;
	assign khy_d = (by_q > nym1) ? nym1 : by_q;
	assign diffx = KW'(col_at_q) - KW'(khx_d) * KW'(sx_c);
	assign diffy = KW'(row_at_q) - KW'(khy_d) * KW'(sy_c);

	assign tmx_d = span_m1(offhx_q, khx_q, sx_c, pw_c);
	assign tmy_d = span_m1(offhy_q, khy_q, sy_c, ph_c);

	assign base_full = BW'(jlo_q) * BW'(nx_q) + BW'(ilo_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			if (depth_q) begin
				p0_q   <= pixel_in.depth_sample;
				p1_q   <= '0;
				p2_q   <= '0;
				unit_q <= 1'b0;
			end else begin
				// byte * 65536 / 255 floors to byte * 257, and 255 saturates to the same
				p0_q   <= {pixel_in.red_byte, pixel_in.red_byte};
				p1_q   <= {pixel_in.green_byte, pixel_in.green_byte};
				p2_q   <= {pixel_in.blue_byte, pixel_in.blue_byte};
				unit_q <= (pixel_in.red_byte == '1);
			end
			col_at_q <= col_q;
			row_at_q <= row_q;
			inside_q <= (SZW'(col_q) < w_c) && (SZW'(row_q) < h_c);
			bx_q     <= SZW'(bx_prod >> RS);
			by_q     <= SZW'(by_prod >> RS);
		end
		if (state_q == F_HI) begin
			khx_q   <= khx_d;
			khy_q   <= khy_d;
			offhx_q <= OFS_W'(diffx);
			offhy_q <= OFS_W'(diffy);
			covx_q  <= (nx_q != '0) && (diffx < KW'(pw_c));
			covy_q  <= (ny_q != '0) && (diffy < KW'(ph_c));
		end
		if (state_q == F_LO) begin
			tmx_q   <= tmx_d;
			tmy_q   <= tmy_d;
			ilo_q   <= khx_q - SZW'(tmx_d);
			jlo_q   <= khy_q - SZW'(tmy_d);
			offlx_q <= OFS_W'(8'(offhx_q) + 8'(tmx_d) * 8'(sx_c));
			offly_q <= OFS_W'(8'(offhy_q) + 8'(tmy_d) * 8'(sy_c));
		end
	end

	assign job_valid      = (state_q == F_PUSH);
	assign job.base_idx   = IDX_W'(base_full);
	assign job.cnt_x_m1   = tmx_q;
	assign job.cnt_y_m1   = tmy_q;
	assign job.offx_lo    = offlx_q;
	assign job.offy_lo    = offly_q;
	assign job.plane0     = p0_q;
	assign job.plane1     = p1_q;
	assign job.plane2     = p2_q;
	assign job.unit       = unit_q;
	assign geom           = geom_q;
	assign nx             = nx_q;

	`IPE_ASSERT(a_cfg_holds_off_pixels, clk, arst_n, cfg_write |=> !pixel_in.ready, "pixel accepted right after a config write")
	`IPE_ASSERT(a_push_only_covered, clk, arst_n, job_valid |-> (inside_q && covx_q && covy_q), "job pushed for an uncovered pixel")

endmodule

// ----- rtl/ipe_queue.sv -----
// Short job queue between the front end and the result sequencer.
// Depends on ipe_pkg (patch_job_t) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipe_queue import ipe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  patch_job_t push_data,
	input  logic       push_valid,
	output logic       push_ready,
	output patch_job_t pop_data,
	output logic       pop_valid,
	input  logic       pop_ready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	patch_job_t        mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`IPE_ASSERT(a_count_bounded, clk, arst_n, count_q <= CW'(DEPTH), "queue count above depth")
	`IPE_ASSERT(a_ptr_gap_matches_count, clk, arst_n, (count_q == '0 || count_q == CW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

// ----- rtl/ipe_back.sv -----
// Result sequencer: walks the covering patches of one job, row outer, column inner.
// Depends on ipe_pkg, ipe_patch_if and assert_macros.svh; fed by ipe_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipe_back import ipe_pkg::*; #(
	parameter int MAX_IMAGE_SIDE = MAX_IMAGE_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  patch_job_t                    job,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  geom_t                         geom,
	input  logic [size_width(MAX_IMAGE_SIDE)-1:0] nx,
	ipe_patch_if.source                   result_out
);

	patch_job_t        job_q;
	logic              busy_q;
	logic [OFS_W-1:0]  cx_q, cy_q;
	logic [OFS_W-1:0]  offx_q, offy_q;
	logic [IDX_W-1:0]  idx_q, row_base_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]  out_idx_q;
	logic [ELEM_W-1:0] out_elem_q;
	logic [VAL_W-1:0]  out_p0_q, out_p1_q, out_p2_q;
	logic              out_unit_q, out_last_q;

	logic              load, emit, last_x, last_y;
	logic [ELEM_W-1:0] elem;
	logic [IDX_W-1:0]  next_row;

	assign job_ready = !busy_q;
	assign load      = job_valid && !busy_q;
	// output register frees when empty or taken this cycle
	assign emit      = busy_q && (!out_valid_q || result_out.ready);
	assign last_x    = (cx_q == job_q.cnt_x_m1);
	assign last_y    = (cy_q == job_q.cnt_y_m1);
	assign elem      = ELEM_W'(offx_q) + ELEM_W'(offy_q) * ELEM_W'(geom.patch_w);
	assign next_row  = row_base_q + IDX_W'(nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cx_q   <= '0;
				cy_q   <= '0;
			end else if (emit) begin
				if (last_x) begin
					cx_q <= '0;
					if (last_y) begin
						busy_q <= 1'b0;
						cy_q   <= '0;
					end else begin
						cy_q <= cy_q + OFS_W'(1);
					end
				end else begin
					cx_q <= cx_q + OFS_W'(1);
				end
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q      <= job;
			idx_q      <= job.base_idx;
			row_base_q <= job.base_idx;
			offx_q     <= job.offx_lo;
			offy_q     <= job.offy_lo;
		end else if (emit) begin
			out_idx_q  <= idx_q;
			out_elem_q <= elem;
			out_p0_q   <= job_q.plane0;
			out_p1_q   <= job_q.plane1;
			out_p2_q   <= job_q.plane2;
			out_unit_q <= job_q.unit;
			out_last_q <= last_x && last_y;
			if (last_x) begin
				offx_q     <= job_q.offx_lo;
				offy_q     <= offy_q - OFS_W'(geom.step_y);
				row_base_q <= next_row;
				idx_q      <= next_row;
			end else begin
				offx_q <= offx_q - OFS_W'(geom.step_x);
				idx_q  <= idx_q + IDX_W'(1);
			end
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.patch_index    = out_idx_q;
	assign result_out.element_offset = out_elem_q;
	assign result_out.plane0_value   = out_p0_q;
	assign result_out.plane1_value   = out_p1_q;
	assign result_out.plane2_value   = out_p2_q;
	assign result_out.unit_value     = out_unit_q;
	assign result_out.last_for_pixel = out_last_q;

	`IPE_ASSERT(a_idle_counters_clear, clk, arst_n, !busy_q |-> (cx_q == '0 && cy_q == '0), "walk counters left nonzero when idle")
	`IPE_ASSERT(a_walk_in_range, clk, arst_n, busy_q |-> (cx_q <= job_q.cnt_x_m1 && cy_q <= job_q.cnt_y_m1), "walk counter past patch span")

endmodule

// ----- rtl/image_patch_extractor_unit.sv -----
// Top level of the image patch extractor: front end, job queue, result sequencer.
// Depends on ipe_pkg, ipe_stream_ifs, ipe_front, ipe_queue and ipe_back.
//
//   channel     dir  handshake      payload
//   pixel_in    in   valid/ready    blue_byte green_byte red_byte depth_sample
//   result_out  out  valid/ready    patch_index element_offset plane0..2 unit last
//   cfg         in   cfg_write      cfg_index (0..6) cfg_data (11 bits)
//
// Front end handles one pixel at a time: accept, coverage range, span, and, for a pixel
// that covers a patch, queue push, which waits while the queue is full.
// The sequencer issues one result per cycle while result_out is ready, after a load
// step per pixel, and takes a new job only when done; the slower side sets the rate.
// Pixel ready drops for one cycle after each config write while counts settle.
// Reset clears the position to row 0, column 0 and loads the default registers.
`timescale 1ns / 1ps

module image_patch_extractor_unit import ipe_pkg::*; #(
	parameter int MAX_PATCH_SIDE = MAX_PATCH_SIDE_DEF,
	parameter int MAX_IMAGE_SIDE = MAX_IMAGE_SIDE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ipe_pixel_if.sink             pixel_in,
	ipe_patch_if.source           result_out
);

	localparam int SZW = size_width(MAX_IMAGE_SIDE);

	patch_job_t     front_job, back_job;
	logic           front_valid, front_ready;
	logic           back_valid, back_ready;
	geom_t          geom;
	logic [SZW-1:0] nx;

	ipe_front #(
		.MAX_PATCH_SIDE (MAX_PATCH_SIDE),
		.MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (pixel_in),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.geom      (geom),
		.nx        (nx)
	);

	ipe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	ipe_back #(
		.MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (back_job),
		.job_valid  (back_valid),
		.job_ready  (back_ready),
		.geom       (geom),
		.nx         (nx),
		.result_out (result_out)
	);

endmodule
